### hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// GHASH accumulator package
// Item types, operation codes, register indexes and the GF(2^128) multiply.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int BlkW   = 128;
	localparam int HalfW  = 64;
	localparam int CountW = 61;
	localparam int NbW    = 5;
	localparam int OpW    = 2;
	localparam int CfgIdxW = 2;

	localparam logic [OpW-1:0] OP_AAD    = 2'd0;
	localparam logic [OpW-1:0] OP_TEXT   = 2'd1;
	localparam logic [OpW-1:0] OP_FINISH = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_KEY_HI = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LO = 2'd1;

	localparam logic [NbW-1:0] BLK_BYTES = 5'd16;

	// Input item.
	typedef struct packed {
		logic [OpW-1:0]   operation;
		logic [HalfW-1:0] data_hi;
		logic [HalfW-1:0] data_lo;
		logic [NbW-1:0]   valid_bytes;
	} gha_in_t;

	// Result item.
	typedef struct packed {
		logic [HalfW-1:0] tag_hi;
		logic [HalfW-1:0] tag_lo;
	} gha_out_t;

	// Decoded block held in the input stage.
	typedef struct packed {
		logic            vld;
		logic            fin;
		logic            is_text;
		logic [NbW-1:0]  nbytes;
		logic [BlkW-1:0] data;
	} gha_blk_t;

	// Product in GF(2^128) with the GCM bit order: bit 127 of the vector is the
	// coefficient of x^0 (MSB of byte 0). A carry-less product is formed first
	// and then folded twice by x^128 = x^7 + x^2 + x + 1.
	function automatic logic [BlkW-1:0] gf_mul(input logic [BlkW-1:0] a,
	                                          input logic [BlkW-1:0] b);
		logic [BlkW-1:0]     ar;
		logic [BlkW-1:0]     br;
		logic [2*BlkW-2:0]   p;
		logic [BlkW-2:0]     h;
		logic [BlkW+5:0]     r1;
		logic [5:0]          g;
		logic [BlkW-1:0]     r2;
		logic [BlkW-1:0]     res;
		for (int i = 0; i < BlkW; i++) begin
			ar[i] = a[BlkW-1-i];
			br[i] = b[BlkW-1-i];
		end
		p = '0;
		for (int i = 0; i < BlkW; i++) begin
			for (int j = 0; j < BlkW; j++) begin
				p[i+j] = p[i+j] ^ (ar[i] & br[j]);
			end
		end
		h  = p[2*BlkW-2:BlkW];
		r1 = {6'b0, p[BlkW-1:0]} ^ {7'b0, h} ^ {6'b0, h, 1'b0} ^
		     {5'b0, h, 2'b0} ^ {h, 7'b0};
		g  = r1[BlkW+5:BlkW];
		r2 = r1[BlkW-1:0] ^ {122'b0, g} ^ {121'b0, g, 1'b0} ^
		     {120'b0, g, 2'b0} ^ {115'b0, g, 7'b0};
		for (int i = 0; i < BlkW; i++) begin
			res[i] = r2[BlkW-1-i];
		end
		return res;
	endfunction

endpackage

### hdl/ghash_accumulator.sv
// ----------------------------------------------------------------------------
// GHASH accumulator
// GCM authentication hash over GF(2^128) with length folding and tag masking.
// ----------------------------------------------------------------------------
// The block takes one 128-bit item per clock cycle while the input is not
// stalled: associated data blocks, text blocks, and a finish item that
// carries the mask E_K(J0). An accepted item is held in the input stage
// register, where the single GF(2^128) multiply by H updates the accumulator;
// that multiply is the longest path and sets the clock. A finish item passes
// from the input stage register into the result register, from which the
// downstream side takes the tag. The next item may already be accepted
// while the finish item is in the input stage. The only stall toward the
// input occurs when a finish item in the input stage meets a tag that the
// downstream side has not yet taken; the finish item then waits there, and
// the input is stalled until that tag is taken. Associated data and text items
// never hold the input stage. Load hash_key_hi and hash_key_lo through the
// configuration port while the block is idle; writes are always taken. Finish
// clears the accumulator and both byte counts but keeps H.
// ----------------------------------------------------------------------------
module ghash_accumulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          blk_valid,
	output logic                          blk_stall,
	input  gha_pkg::gha_in_t              blk,
	output logic                          tag_valid,
	input  logic                          tag_stall,
	output gha_pkg::gha_out_t             tag,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gha_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [gha_pkg::HalfW-1:0]     cfg_data
);
	import gha_pkg::*;

	logic [HalfW-1:0] key_hi_q;
	logic [HalfW-1:0] key_lo_q;
	gha_blk_t         blk_s1;
	gha_out_t         tag_d;
	logic             accept;
	logic             adv;
	logic             fin_stuck;

	// Configuration writes are accepted in every cycle; unknown indexes are
	// dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_HI: key_hi_q <= cfg_data;
				REG_KEY_LO: key_lo_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A finish item may only leave the input stage if the result register is
	// free or being emptied in this cycle.
	assign fin_stuck = blk_s1.vld && blk_s1.fin && tag_valid && tag_stall;
	assign adv       = !fin_stuck;
	assign blk_stall = fin_stuck;
	assign accept    = blk_valid && !blk_stall;

	gha_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.adv    (adv),
		.blk    (blk),
		.blk_s1 (blk_s1)
	);

	gha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.blk_s1 (blk_s1),
		.hkey   ({key_hi_q, key_lo_q}),
		.tag_d  (tag_d)
	);

	gha_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (blk_s1.vld && blk_s1.fin && adv),
		.tag_d     (tag_d),
		.tag_stall (tag_stall),
		.tag_valid (tag_valid),
		.tag       (tag)
	);

endmodule

### hdl/gha_prep.sv
// ----------------------------------------------------------------------------
// GHASH input stage
// Decodes an accepted item, zeroes the bytes past the valid count of data and
// text blocks and holds the block in the stage register.
// ----------------------------------------------------------------------------
module gha_prep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             adv,
	input  gha_pkg::gha_in_t blk,
	output gha_pkg::gha_blk_t blk_s1
);
	import gha_pkg::*;

	logic [NbW-1:0]  nsat;
	logic [BlkW-1:0] mask;
	logic            keep;
	logic            fin;
	logic            is_text;
	logic            vld_s1;
	gha_blk_t        pay_s1;

	assign nsat = (blk.valid_bytes > BLK_BYTES) ? BLK_BYTES : blk.valid_bytes;

	always_comb begin
		for (int b = 0; b < BlkW / 8; b++) begin
			mask[BlkW-1-8*b -: 8] = (NbW'(b) < nsat) ? 8'hff : 8'h00;
		end
	end

	// Code 3 and empty associated data or text blocks are taken but leave no trace.
	always_comb begin
		keep    = 1'b0;
		fin     = 1'b0;
		is_text = 1'b0;
		unique case (blk.operation)
			OP_AAD: begin
				keep = (blk.valid_bytes != '0);
			end
			OP_TEXT: begin
				keep    = (blk.valid_bytes != '0);
				is_text = 1'b1;
			end
			OP_FINISH: begin
				keep = 1'b1;
				fin  = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pay_s1.vld     <= 1'b1;
			pay_s1.fin     <= fin;
			pay_s1.is_text <= is_text;
			pay_s1.nbytes  <= nsat;
			pay_s1.data    <= fin ? {blk.data_hi, blk.data_lo}
			                      : ({blk.data_hi, blk.data_lo} & mask);
		end
	end

	always_comb begin
		blk_s1     = pay_s1;
		blk_s1.vld = vld_s1;
	end

endmodule

### hdl/gha_core.sv
// ----------------------------------------------------------------------------
// GHASH core
// Holds the accumulator and byte counts and performs one multiply by H per
// block; on finish it folds in the lengths and forms the tag.
// ----------------------------------------------------------------------------
module gha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  gha_pkg::gha_blk_t blk_s1,
	input  logic [127:0]      hkey,
	output gha_pkg::gha_out_t tag_d
);
	import gha_pkg::*;

	logic [BlkW-1:0]   acc_q;
	logic [CountW-1:0] aad_cnt_q;
	logic [CountW-1:0] text_cnt_q;
	logic [BlkW-1:0]   operand;
	logic [BlkW-1:0]   prod;
	logic [BlkW-1:0]   tag_v;
	logic              upd;

	assign operand = blk_s1.fin ? {aad_cnt_q, 3'b000, text_cnt_q, 3'b000} : blk_s1.data;
	assign prod    = gf_mul(acc_q ^ operand, hkey);
	assign tag_v   = prod ^ blk_s1.data;
	assign tag_d   = '{tag_hi: tag_v[BlkW-1:HalfW], tag_lo: tag_v[HalfW-1:0]};
	assign upd     = blk_s1.vld && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			aad_cnt_q  <= '0;
			text_cnt_q <= '0;
		end else if (upd) begin
			if (blk_s1.fin) begin
				acc_q      <= '0;
				aad_cnt_q  <= '0;
				text_cnt_q <= '0;
			end else begin
				acc_q <= prod;
				if (blk_s1.is_text) begin
					text_cnt_q <= text_cnt_q + {{(CountW-NbW){1'b0}}, blk_s1.nbytes};
				end else begin
					aad_cnt_q <= aad_cnt_q + {{(CountW-NbW){1'b0}}, blk_s1.nbytes};
				end
			end
		end
	end

endmodule

### hdl/gha_out_reg.sv
// ----------------------------------------------------------------------------
// GHASH result register
// Holds one tag until the downstream side takes it.
// ----------------------------------------------------------------------------
module gha_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gha_pkg::gha_out_t tag_d,
	input  logic              tag_stall,
	output logic              tag_valid,
	output gha_pkg::gha_out_t tag
);
	import gha_pkg::*;

	logic     vld_q;
	gha_out_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!tag_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q <= tag_d;
		end
	end

	assign tag_valid = vld_q;
	assign tag       = tag_q;

endmodule
